### src/motion_tween_stepper_unit_macros.svh
// Assertion macros for the motion tween stepper.
`ifndef MOTION_TWEEN_STEPPER_UNIT_MACROS_SVH
`define MOTION_TWEEN_STEPPER_UNIT_MACROS_SVH
`ifndef SYNTH
`define MTS_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`define MTS_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
`else
`define MTS_ASSERT_NEXT(lbl, a, b)
`define MTS_ASSERT_NOW(lbl, a, b)
`endif
`endif

### src/mts_pkg.sv
// Shared types and constants for the motion tween stepper.
package mts_pkg;

  localparam int AXES  = 3;
  localparam int POS_W = 32;
  localparam int CNT_W = 16;
  localparam int IDX_W = 8;

  typedef enum logic [1:0] {
    MODE_DIRECT   = 2'd0,
    MODE_INTERP   = 2'd1,
    MODE_TRIP     = 2'd2,
    MODE_TRIP_LNG = 2'd3
  } mode_t;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_BEGIN = 1'b1;

  localparam logic [IDX_W-1:0] REG_MODE      = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_WAIT      = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_LEG_TICKS = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_LEG_COUNT = IDX_W'(3);

  typedef enum logic [2:0] {
    LANE_HOLD,
    LANE_LOAD,
    LANE_END,
    LANE_CLAMP,
    LANE_ADD,
    LANE_START
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     negate;
  } lane_ctl_t;

endpackage

### src/mts_lane.sv
// One axis lane: position, step, start and target registers and the step/clamp datapath.
module mts_lane
  import mts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lane_ctl_t        ctl,
  input  logic [POS_W-1:0] ld_start,
  input  logic [POS_W-1:0] ld_tgt,
  input  logic [POS_W-1:0] ld_step,
  output logic [POS_W-1:0] pos_next,
  output logic             arrived
);

  logic [POS_W-1:0] position, position_next;
  logic [POS_W-1:0] step, step_next;
  logic [POS_W-1:0] start;
  logic [POS_W-1:0] tgt;
  logic [POS_W:0]   sum;

  assign sum = {position[POS_W-1], position} + {step[POS_W-1], step};

  always_comb begin
    if (step[POS_W-1]) begin
      arrived = $signed(sum) <= $signed({tgt[POS_W-1], tgt});
    end else begin
      arrived = $signed(sum) >= $signed({tgt[POS_W-1], tgt});
    end
  end

  always_comb begin
    unique case (ctl.op)
      LANE_HOLD:  position_next = position;
      LANE_LOAD:  position_next = ld_start;
      LANE_END:   position_next = tgt;
      LANE_CLAMP: position_next = arrived ? tgt : sum[POS_W-1:0];
      LANE_ADD:   position_next = sum[POS_W-1:0];
      LANE_START: position_next = start;
      default:    position_next = position;
    endcase
    if (ctl.op == LANE_LOAD) begin
      step_next = ld_step;
    end else if (ctl.negate) begin
      step_next = POS_W'(0) - step;
    end else begin
      step_next = step;
    end
  end

  assign pos_next = position_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      step     <= '0;
      start    <= '0;
      tgt      <= '0;
    end else begin
      position <= position_next;
      step     <= step_next;
      if (ctl.op == LANE_LOAD) begin
        start <= ld_start;
        tgt   <= ld_tgt;
      end
    end
  end

endmodule

### src/mts_ctrl.sv
// Mode control: configuration registers, wait prescaler, leg counters and done merge.
module mts_ctrl
  import mts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             fire,
  input  logic             cmd,
  input  logic [AXES-1:0]  arrived,
  output lane_ctl_t        ctl,
  output logic             done
);

  mode_t            mode;
  logic [CNT_W-1:0] wait_reload;
  logic [CNT_W-1:0] leg_ticks;
  logic [CNT_W-1:0] leg_count;

  logic [CNT_W-1:0] wait_left, wait_left_next;
  logic [CNT_W-1:0] leg_timer, leg_timer_next;
  logic [CNT_W-1:0] legs_left, legs_left_next;
  logic             finished, finished_next;
  logic [CNT_W-1:0] timer_dec;
  logic             all_arrived;

  assign all_arrived = &arrived;
  assign timer_dec   = leg_timer - CNT_W'(1);

  always_comb begin
    wait_left_next = wait_left;
    leg_timer_next = leg_timer;
    legs_left_next = legs_left;
    finished_next  = finished;
    ctl.op         = LANE_HOLD;
    ctl.negate     = 1'b0;
    done           = 1'b0;
    if (fire) begin
      if (cmd == CMD_BEGIN) begin
        ctl.op         = LANE_LOAD;
        wait_left_next = wait_reload;
        leg_timer_next = leg_ticks;
        legs_left_next = leg_count;
        finished_next  = 1'b0;
      end else if (finished) begin
        done = 1'b1;
      end else begin
        unique case (mode)
          MODE_DIRECT: begin
            ctl.op        = LANE_END;
            finished_next = 1'b1;
            done          = 1'b1;
          end
          MODE_INTERP: begin
            if (wait_left != '0) begin
              wait_left_next = wait_left - CNT_W'(1);
            end else begin
              wait_left_next = wait_reload;
              ctl.op         = LANE_CLAMP;
              finished_next  = all_arrived;
              done           = all_arrived;
            end
          end
          MODE_TRIP, MODE_TRIP_LNG: begin
            if (wait_left != '0) begin
              wait_left_next = wait_left - CNT_W'(1);
            end else begin
              wait_left_next = wait_reload;
              ctl.op         = LANE_ADD;
              leg_timer_next = timer_dec;
              if (timer_dec == '0) begin
                legs_left_next = legs_left - CNT_W'(1);
                leg_timer_next = leg_ticks;
                ctl.negate     = (mode == MODE_TRIP) || legs_left_next[0];
              end
            end
            if (legs_left_next == '0) begin
              ctl.op        = LANE_START;
              finished_next = 1'b1;
              done          = 1'b1;
            end
          end
          default: ctl.op = LANE_HOLD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_DIRECT;
      wait_reload <= '0;
      leg_ticks   <= CNT_W'(1);
      leg_count   <= CNT_W'(2);
      wait_left   <= '0;
      leg_timer   <= CNT_W'(1);
      legs_left   <= '0;
      finished    <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:      mode        <= mode_t'(cfg_data[1:0]);
          REG_WAIT:      wait_reload <= cfg_data;
          REG_LEG_TICKS: leg_ticks   <= cfg_data;
          REG_LEG_COUNT: leg_count   <= cfg_data;
          default:       ;
        endcase
      end
      wait_left <= wait_left_next;
      leg_timer <= leg_timer_next;
      legs_left <= legs_left_next;
      finished  <= finished_next;
    end
  end

endmodule

### src/motion_tween_stepper_unit.sv
// Top level of the three-axis motion tween stepper with output register.
// Usage:
//   Input stream s_*: one beat per command. s_tuser is the command (tick or
//   begin); s_tdata carries the start, target and step vectors, used only by
//   a begin beat. Each input beat yields exactly one output beat on m_*,
//   carrying the three axis positions in m_tdata and the done flag in m_tlast.
//   Latency: the result is valid the cycle after the input beat is taken.
//   Throughput: one beat per cycle; the whole state update for an item is a
//   single 33-bit add and compare per axis lane plus the counter logic.
//   A stalled receiver holds the output register; a new input beat is taken
//   in the same cycle the held result leaves, so back-pressure passes through
//   with no bubble.
//   Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only
//   while no beats are in flight. Indexes 0 mode, 1 wait reload, 2 leg
//   ticks, 3 leg count; other indexes are ignored.
//   Reset: synchronous, active high. Clears the registers to their defaults,
//   positions to zero and marks the motion finished; the output is emptied.
`include "motion_tween_stepper_unit_macros.svh"
module motion_tween_stepper_unit
  import mts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [9*POS_W-1:0]   s_tdata,   // start_x, start_y, start_z, end_x, end_y,
                                          // end_z, step_x, step_y, step_z
  input  logic                 s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [AXES*POS_W-1:0] m_tdata,  // pos_x, pos_y, pos_z
  output logic                 m_tlast,   // done_res
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CNT_W-1:0]     cfg_data
);

  logic                    fire;
  lane_ctl_t               ctl;
  logic                    done;
  logic [AXES-1:0]         arrived;
  logic [POS_W-1:0]        pos_next [AXES];

  assign s_tready  = !m_tvalid || m_tready;
  assign fire      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .cmd       (s_tuser),
    .arrived   (arrived),
    .ctl       (ctl),
    .done      (done)
  );

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    mts_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .ld_start (s_tdata[a*POS_W +: POS_W]),
      .ld_tgt   (s_tdata[(AXES+a)*POS_W +: POS_W]),
      .ld_step  (s_tdata[(2*AXES+a)*POS_W +: POS_W]),
      .pos_next (pos_next[a]),
      .arrived  (arrived[a])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int a = 0; a < AXES; a++) begin
        m_tdata[a*POS_W +: POS_W] <= pos_next[a];
      end
      m_tlast <= done;
    end
  end

  `MTS_ASSERT_NEXT(a_beat_out, fire, m_tvalid)
  `MTS_ASSERT_NEXT(a_begin_not_done, fire && s_tuser == CMD_BEGIN, !m_tlast)
  `MTS_ASSERT_NOW(a_no_overrun, m_tvalid && !m_tready, !s_tready)

endmodule

### verif/tb_motion_tween_stepper_unit.sv
// Self-checking bench for the motion tween stepper, with an inline predictor.
module tb_motion_tween_stepper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;

  localparam int IDLE_MAX     = 14;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1100;
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_TOP    = '1;

  typedef logic [AXES-1:0][POS_W-1:0] axes_t;

  typedef struct packed {
    logic                         cmd;
    logic [3*AXES-1:0][POS_W-1:0] vec;   // start x/y/z, end x/y/z, step x/y/z
  } move_beat_t;

  typedef struct packed {
    axes_t pos;
    logic  done;
  } pos_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [9*POS_W-1:0]     s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [AXES*POS_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [IDX_W-1:0]       cfg_index = '0;
  logic [CNT_W-1:0]       cfg_data = '0;

  motion_tween_stepper_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and motion state
  mode_t            cur_mode    = MODE_DIRECT;
  logic [CNT_W-1:0] wait_reload = '0;
  logic [CNT_W-1:0] leg_ticks   = CNT_W'(1);
  logic [CNT_W-1:0] leg_count   = CNT_W'(2);
  axes_t            cur_pos = '0, step_v = '0, start_v = '0, end_v = '0;
  logic [CNT_W-1:0] wait_left = '0, leg_timer = CNT_W'(1), legs_left = '0;
  bit               finished = 1'b1;

  move_beat_t  send_q[$];
  pos_result_t expected_pos_q[$];
  move_beat_t  cur_item;

  int  queued_beats = 0, checked_beats = 0, begin_beats = 0, done_beats = 0;
  int  error_count = 0, phase_count = 0, quiet_cycles = 0;
  int  mode_ticks[4] = '{0, 0, 0, 0};
  int  gap_left = 0, stall_left = 0;
  bit  in_taken = 1'b0, out_taken = 1'b0, idle_on = 1'b0;
  string axis_name[AXES] = '{"pos_x", "pos_y", "pos_z"};

  function automatic int draw_idle();
    return idle_on ? int'($urandom_range(0, IDLE_MAX)) : 0;
  endfunction

  function automatic pos_result_t advance_motion(move_beat_t b);
    pos_result_t r;
    longint      sum_v, step_s, end_s;
    bit          arrived, all_in;
    r.done = 1'b0;
    if (b.cmd == CMD_BEGIN) begin
      for (int a = 0; a < AXES; a++) begin
        start_v[a] = b.vec[a];
        end_v[a]   = b.vec[AXES + a];
        step_v[a]  = b.vec[2*AXES + a];
      end
      cur_pos   = start_v;
      wait_left = wait_reload;
      leg_timer = leg_ticks;
      legs_left = leg_count;
      finished  = 1'b0;
    end else if (finished) begin
      r.done = 1'b1;
    end else if (cur_mode == MODE_DIRECT) begin
      cur_pos  = end_v;
      finished = 1'b1;
      r.done   = 1'b1;
    end else if (cur_mode == MODE_INTERP) begin
      if (wait_left != 0) begin
        wait_left = wait_left - CNT_W'(1);
      end else begin
        wait_left = wait_reload;
        all_in = 1'b1;
        for (int a = 0; a < AXES; a++) begin
          step_s  = longint'($signed(step_v[a]));
          end_s   = longint'($signed(end_v[a]));
          sum_v   = longint'($signed(cur_pos[a])) + step_s;
          arrived = (step_s < 0) ? (sum_v <= end_s) : (sum_v >= end_s);
          cur_pos[a] = arrived ? end_v[a] : sum_v[POS_W-1:0];
          all_in = all_in & arrived;
        end
        finished = all_in;
        r.done   = all_in;
      end
    end else begin
      if (wait_left != 0) begin
        wait_left = wait_left - CNT_W'(1);
      end else begin
        wait_left = wait_reload;
        for (int a = 0; a < AXES; a++) cur_pos[a] = cur_pos[a] + step_v[a];
        leg_timer = leg_timer - CNT_W'(1);
        if (leg_timer == 0) begin
          legs_left = legs_left - CNT_W'(1);
          leg_timer = leg_ticks;
          if (cur_mode == MODE_TRIP || legs_left[0]) begin
            for (int a = 0; a < AXES; a++) step_v[a] = -step_v[a];
          end
        end
      end
      if (legs_left == 0) begin
        cur_pos  = start_v;
        finished = 1'b1;
        r.done   = 1'b1;
      end
    end
    r.pos = cur_pos;
    return r;
  endfunction

  // input beat driver
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
      end else if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (send_q.size() > 0) begin
        cur_item = send_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur_item.cmd;
        s_tdata  <= cur_item.vec;
        gap_left = draw_idle();
      end else begin
        s_tvalid <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (out_taken) stall_left = draw_idle();
    out_taken = 1'b0;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: check results, then predict for the beat taken at this edge
  always @(posedge clk) begin
    pos_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_taken = 1'b1;
        if (expected_pos_q.size() == 0) begin
          $error("result beat with no expectation pending");
          error_count++;
        end else begin
          want = expected_pos_q.pop_front();
          for (int a = 0; a < AXES; a++) begin
            if (m_tdata[a*POS_W +: POS_W] !== want.pos[a]) begin
              $error("%s expected %h actual %h", axis_name[a], want.pos[a],
                     m_tdata[a*POS_W +: POS_W]);
              error_count++;
            end
          end
          if (m_tlast !== want.done) begin
            $error("done_res expected %b actual %b", want.done, m_tlast);
            error_count++;
          end
          if (want.done) done_beats++;
          checked_beats++;
        end
      end
      if (s_tvalid && s_tready) begin
        if (cur_item.cmd == CMD_BEGIN) begin_beats++;
        else mode_ticks[cur_mode]++;
        expected_pos_q.push_back(advance_motion(cur_item));
        in_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODE:      cur_mode    = mode_t'(data[1:0]);
      REG_WAIT:      wait_reload = data;
      REG_LEG_TICKS: leg_ticks   = data;
      REG_LEG_COUNT: leg_count   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input mode_t m, input logic [CNT_W-1:0] w, lt, lc);
    write_reg(REG_MODE, CNT_W'(m));
    write_reg(REG_WAIT, w);
    write_reg(REG_LEG_TICKS, lt);
    write_reg(REG_LEG_COUNT, lc);
  endtask

  task automatic drain_results();
    while (checked_beats != queued_beats) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic queue_begin(input logic [POS_W-1:0] sx, sy, sz, ex, ey, ez, tx, ty, tz);
    move_beat_t b;
    b.cmd = CMD_BEGIN;
    b.vec = {tz, ty, tx, ez, ey, ex, sz, sy, sx};
    send_q.push_back(b);
    queued_beats++;
  endtask

  task automatic queue_tick();
    move_beat_t b;
    b.cmd = CMD_TICK;
    for (int k = 0; k < 3*AXES; k++) b.vec[k] = $urandom;
    send_q.push_back(b);
    queued_beats++;
  endtask

  function automatic logic [POS_W-1:0] pick_coord();
    case ($urandom_range(0, 4))
      0, 1: return POS_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      2, 3: return $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          3: return '1;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  // mostly reachable targets, with a step of the distance divided by one to six
  task automatic queue_random_begin();
    logic [POS_W-1:0] s[AXES], e[AXES], t[AXES];
    int delta, n;
    for (int a = 0; a < AXES; a++) begin
      if ($urandom_range(0, 3) != 0) begin
        s[a]  = pick_coord();
        delta = int'($urandom_range(0, 1 << 17)) - (1 << 16);
        n     = $urandom_range(1, 6);
        e[a]  = s[a] + delta;
        t[a]  = delta / n;
        if ($urandom_range(0, 9) == 0) t[a] = -t[a];
      end else begin
        s[a] = pick_coord();
        e[a] = pick_coord();
        t[a] = pick_coord();
      end
    end
    queue_begin(s[0], s[1], s[2], e[0], e[1], e[2], t[0], t[1], t[2]);
  endtask

  initial begin
    int target, phase_len, run_len;
    logic [CNT_W-1:0] w, lt, lc;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // direct mode from reset: hold before any begin, jump, hold
    queue_tick();
    queue_begin(32'h8000_0000, 32'h7fff_ffff, '0, 32'h7fff_ffff, 32'h8000_0000, '1,
                32'h0000_0001, '1, '0);
    queue_tick();
    queue_tick();
    drain_results();

    // interpolation with clamping on both signs and a zero step
    set_regs(MODE_INTERP, '0, CNT_W'(1), CNT_W'(2));
    queue_begin('0, '0, '0, 32'd5, -32'sd5, '0, 32'd2, -32'sd2, '0);
    repeat (4) queue_tick();
    drain_results();

    // prescaler, and sums beyond the 32-bit range that must not wrap
    write_reg(REG_WAIT, CNT_W'(1));
    queue_begin(32'h7fff_ffff, 32'h8000_0000, '0, 32'h8000_0000, 32'h7fff_ffff,
                32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, '0);
    queue_tick();
    queue_tick();
    drain_results();

    // plain round trip over three legs
    set_regs(MODE_TRIP, '0, CNT_W'(2), CNT_W'(3));
    queue_begin(32'h1000, -32'sh1000, '0, '0, '0, '0, 32'h100, 32'h80, '1);
    repeat (6) queue_tick();
    drain_results();

    // zero leg ticks and zero legs: done at once
    set_regs(MODE_TRIP_LNG, '0, '0, '0);
    queue_begin($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    queue_tick();
    drain_results();

    // zero legs but the first tick ends a leg: count wraps, motion goes on
    write_reg(REG_LEG_TICKS, CNT_W'(1));
    queue_begin(32'h10, 32'h20, 32'h30, '0, '0, '0, 32'h1, -32'sh1, 32'h7fff_ffff);
    queue_tick();
    queue_tick();
    drain_results();

    // mode change mid-motion, stray register indexes ignored
    write_reg(REG_MODE, CNT_W'(MODE_INTERP));
    write_reg(REG_UNUSED, '1);
    write_reg(REG_TOP, '0);
    queue_tick();
    queue_tick();
    drain_results();

    target = queued_beats + RANDOM_ITEMS;
    while (queued_beats < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase_count == 0) begin
        set_regs(MODE_TRIP_LNG, '1, '1, '1);
      end else begin
        case ($urandom_range(0, 9))
          0:       w = '1;
          1, 2, 3: w = CNT_W'($urandom_range(1, 3));
          default: w = '0;
        endcase
        case ($urandom_range(0, 9))
          0:       lt = '0;
          1:       lt = '1;
          default: lt = CNT_W'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 9))
          0:       lc = '1;
          default: lc = CNT_W'($urandom_range(0, 5));
        endcase
        set_regs(mode_t'($urandom_range(0, 3)), w, lt, lc);
        if ($urandom_range(0, 4) == 0)
          write_reg($urandom_range(0, 1) ? REG_UNUSED : REG_TOP, CNT_W'($urandom));
      end
      phase_count++;
      phase_len = queued_beats + int'($urandom_range(30, 70));
      // carry the previous motion into the new setting
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) queue_tick();
      while (queued_beats < phase_len) begin
        if ($urandom_range(0, 9) != 0) queue_random_begin();
        run_len = $urandom_range(0, 20);
        repeat (run_len) queue_tick();
      end
      drain_results();
    end

    if (expected_pos_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_pos_q.size());
      error_count++;
    end
    $display("%0d beats checked over %0d random phases: %0d begins, %0d finished results",
             checked_beats, phase_count, begin_beats, done_beats);
    $display("ticks by mode: direct %0d, interpolate %0d, round trip %0d, long %0d",
             mode_ticks[0], mode_ticks[1], mode_ticks[2], mode_ticks[3]);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/mts_pkg.sv
src/mts_lane.sv
src/mts_ctrl.sv
src/motion_tween_stepper_unit.sv
verif/tb_motion_tween_stepper_unit.sv
